// ===== rtl/alb_pkg.sv =====
// ----------------------------------------------------------------------------
// alb_pkg
// Shared widths, constants and lookup tables for the log brightness pipeline.
// ----------------------------------------------------------------------------
package alb_pkg;

   localparam int CompWidth   = 19;
   localparam int CountWidth  = 8;
   localparam int MagWidth    = 8;
   localparam int SumWidth    = 16;
   localparam int MsbWidth    = 4;
   localparam int FracBits    = 6;
   localparam int LogWidth    = 10;
   localparam int CorrWidth   = 9;
   localparam int BrightWidth = 8;
   localparam int MagShift    = 10;
   localparam int TableLen    = 64;
   localparam int LogFloor    = 32;
   localparam int ExpCap      = 1023;
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 8;

   // Fraction of log2(1 + i/64), six bits
   localparam logic [FracBits-1:0] LOG_MANT [TableLen] = '{
      6'd0,  6'd1,  6'd3,  6'd4,  6'd6,  6'd7,  6'd8,  6'd10,
      6'd11, 6'd12, 6'd13, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
      6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
      6'd29, 6'd30, 6'd31, 6'd32, 6'd34, 6'd35, 6'd35, 6'd36,
      6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44,
      6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49, 6'd50, 6'd51,
      6'd52, 6'd52, 6'd53, 6'd54, 6'd55, 6'd56, 6'd56, 6'd57,
      6'd58, 6'd59, 6'd60, 6'd60, 6'd61, 6'd62, 6'd63, 6'd63
   };

   // 64 * 2^(i/64), seven bits
   localparam logic [6:0] EXP_MANT [TableLen] = '{
      7'd64,  7'd65,  7'd65,  7'd66,  7'd67,  7'd68,  7'd68,  7'd69,
      7'd70,  7'd71,  7'd71,  7'd72,  7'd73,  7'd74,  7'd74,  7'd75,
      7'd76,  7'd77,  7'd78,  7'd79,  7'd79,  7'd80,  7'd81,  7'd82,
      7'd83,  7'd84,  7'd85,  7'd86,  7'd87,  7'd88,  7'd89,  7'd90,
      7'd91,  7'd91,  7'd92,  7'd93,  7'd95,  7'd96,  7'd97,  7'd98,
      7'd99,  7'd100, 7'd101, 7'd102, 7'd103, 7'd104, 7'd105, 7'd106,
      7'd108, 7'd109, 7'd110, 7'd111, 7'd112, 7'd114, 7'd115, 7'd116,
      7'd117, 7'd119, 7'd120, 7'd121, 7'd123, 7'd124, 7'd125, 7'd127
   };

   // Log-domain correction indexed by cycle count minus one
   localparam logic [CorrWidth-1:0] CYCLE_CORR [TableLen] = '{
      9'd384, 9'd320, 9'd283, 9'd256, 9'd235, 9'd219, 9'd204, 9'd192,
      9'd181, 9'd171, 9'd163, 9'd155, 9'd147, 9'd140, 9'd134, 9'd128,
      9'd122, 9'd117, 9'd112, 9'd107, 9'd103, 9'd99,  9'd94,  9'd91,
      9'd87,  9'd83,  9'd80,  9'd76,  9'd73,  9'd70,  9'd67,  9'd64,
      9'd61,  9'd58,  9'd56,  9'd53,  9'd51,  9'd48,  9'd46,  9'd43,
      9'd41,  9'd39,  9'd37,  9'd35,  9'd33,  9'd30,  9'd29,  9'd27,
      9'd25,  9'd23,  9'd21,  9'd19,  9'd17,  9'd16,  9'd14,  9'd12,
      9'd11,  9'd9,   9'd8,   9'd6,   9'd4,   9'd3,   9'd1,   9'd0
   };

   // Leading-one position and normalised mantissa index of the sum of squares
   typedef struct packed {
      logic [MsbWidth-1:0] msb;
      logic [FracBits-1:0] idx;
   } lod_type;

endpackage

// ===== rtl/alb_mag.sv =====
// ----------------------------------------------------------------------------
// alb_mag
// Magnitude of a signed component, scaled down and saturated to eight bits.
// ----------------------------------------------------------------------------
module alb_mag (
   input  logic signed [alb_pkg::CompWidth-1:0] comp,
   output logic        [alb_pkg::MagWidth-1:0]  mag
);

   logic [alb_pkg::CompWidth-1:0]                    abs_val;
   logic [alb_pkg::CompWidth-alb_pkg::MagShift-1:0]  scaled;

   always_comb begin
      abs_val = comp[alb_pkg::CompWidth-1] ? (~comp + 1'b1) : comp;
      scaled  = abs_val[alb_pkg::CompWidth-1:alb_pkg::MagShift];
      // saturate the single out-of-range case (most negative input)
      if (scaled[alb_pkg::CompWidth-alb_pkg::MagShift-1]) begin
         mag = '1;
      end else begin
         mag = scaled[alb_pkg::MagWidth-1:0];
      end
   end

endmodule

// ===== rtl/alb_sqsum.sv =====
// ----------------------------------------------------------------------------
// alb_sqsum
// Square both magnitudes, halve each square and add.
// ----------------------------------------------------------------------------
module alb_sqsum (
   input  logic [alb_pkg::MagWidth-1:0] mag_s,
   input  logic [alb_pkg::MagWidth-1:0] mag_c,
   output logic [alb_pkg::SumWidth-1:0] sum
);

   logic [2*alb_pkg::MagWidth-1:0] sq_s;
   logic [2*alb_pkg::MagWidth-1:0] sq_c;

   always_comb begin
      sq_s = mag_s * mag_s;
      sq_c = mag_c * mag_c;
      sum  = alb_pkg::SumWidth'(sq_s >> 1) + alb_pkg::SumWidth'(sq_c >> 1);
   end

endmodule

// ===== rtl/alb_lod.sv =====
// ----------------------------------------------------------------------------
// alb_lod
// Leading-one detect and normalise: position of the top bit and the six bits
// below it.
// ----------------------------------------------------------------------------
module alb_lod (
   input  logic [alb_pkg::SumWidth-1:0] sum,
   output alb_pkg::lod_type             lod
);

   logic [alb_pkg::MsbWidth-1:0] msb;
   logic [alb_pkg::SumWidth-1:0] norm;

   always_comb begin
      msb = '0;
      for (int i = 0; i < alb_pkg::SumWidth; i++) begin
         if (sum[i]) begin
            msb = alb_pkg::MsbWidth'(i);
         end
      end
      // align the leading one with the top bit; the index sits just below it
      norm    = sum << (alb_pkg::MsbWidth'(alb_pkg::SumWidth - 1) - msb);
      lod.msb = msb;
      lod.idx = norm[alb_pkg::SumWidth-2 -: alb_pkg::FracBits];
   end

endmodule

// ===== rtl/alb_exp2.sv =====
// ----------------------------------------------------------------------------
// alb_exp2
// Map a six-fraction-bit log value back through the exp2 table and a shift,
// saturating to eight bits; an item that is not live gives zero.
// ----------------------------------------------------------------------------
module alb_exp2 (
   input  logic [alb_pkg::LogWidth-1:0]    log_val,
   input  logic                            live,
   output logic [alb_pkg::BrightWidth-1:0] bright
);

   logic [alb_pkg::LogWidth-alb_pkg::FracBits-1:0] sh;
   logic [6:0]                                     mant;
   logic [alb_pkg::SumWidth-1:0]                   wide;

   always_comb begin
      sh   = log_val[alb_pkg::LogWidth-1:alb_pkg::FracBits];
      mant = alb_pkg::EXP_MANT[log_val[alb_pkg::FracBits-1:0]];
      wide = '0;
      if (!live) begin
         bright = '0;
      end else if (sh >= alb_pkg::FracBits) begin
         wide = alb_pkg::SumWidth'(mant) << (sh - 4'(alb_pkg::FracBits));
         if (wide[alb_pkg::SumWidth-1:alb_pkg::BrightWidth] != '0) begin
            bright = '1;
         end else begin
            bright = wide[alb_pkg::BrightWidth-1:0];
         end
      end else begin
         bright = alb_pkg::BrightWidth'(mant >> (4'(alb_pkg::FracBits) - sh));
      end
   end

endmodule

// ===== rtl/alb_corr.sv =====
// ----------------------------------------------------------------------------
// alb_corr
// Build the log from the leading-one result, halve it, add the cycle-count
// correction and remove the floor.
// ----------------------------------------------------------------------------
module alb_corr (
   input  alb_pkg::lod_type                lod,
   input  logic                            n_ok,
   input  logic [alb_pkg::FracBits-1:0]    cidx,
   output logic [alb_pkg::LogWidth-1:0]    log_val,
   output logic                            live
);

   logic [alb_pkg::LogWidth-1:0] lg;
   logic [alb_pkg::LogWidth:0]   half;
   logic [alb_pkg::LogWidth:0]   corr;
   logic [alb_pkg::LogWidth:0]   floored;

   always_comb begin
      lg      = {lod.msb, alb_pkg::LOG_MANT[lod.idx]};
      half    = (alb_pkg::LogWidth+1)'((lg + 11'(alb_pkg::TableLen)) >> 1);
      corr    = half + (alb_pkg::LogWidth+1)'(alb_pkg::CYCLE_CORR[cidx]);
      floored = corr - 11'(alb_pkg::LogFloor);
      // drop the item when the count is out of range, the log is zero or
      // the corrected log does not clear the floor
      live    = n_ok && (lg != '0) && (corr > 11'(alb_pkg::LogFloor));
      if (floored > 11'(alb_pkg::ExpCap)) begin
         log_val = alb_pkg::LogWidth'(alb_pkg::ExpCap);
      end else begin
         log_val = floored[alb_pkg::LogWidth-1:0];
      end
   end

endmodule

// ===== rtl/amplitude_to_log_brightness.sv =====
// ----------------------------------------------------------------------------
// amplitude_to_log_brightness
// Quadrature amplitude to log-compressed LED brightness, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on the req_ stream (tvalid/tready/tdata) and carry the
//   signed sine and cosine components and the filter cycle count. Each beat
//   yields exactly one brightness beat on the rsp_ stream, in order.
//   The five register stages are magnitude, square-sum, leading-one detect,
//   log correction and exp2 output register. Throughput is one beat per
//   cycle while the receiver keeps rsp_tready high.
//   Each stage holds a valid bit and advances when it is empty or when the
//   stage after it advances, so bubbles close up and a stalled receiver
//   backs the pipeline up stage by stage without losing or repeating a beat;
//   req_tready drops only once all five stages are full and rsp_tready is low.
//   Reset clears every valid bit; the block is then empty and ready, and no
//   beat is in flight. The block keeps no state between beats.
//   A cycle count of zero or above 64, a sum of squares of zero or one, and
//   a corrected log at or below the floor all give a brightness of zero.
// ----------------------------------------------------------------------------
module amplitude_to_log_brightness (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [18:0] sine_component, [37:19] cosine_component,
   //            [45:38] cycle_count, [47:46] zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [alb_pkg::ReqDataWidth-1:0]     req_tdata,
   // rsp_tdata: [7:0] brightness
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [alb_pkg::RspDataWidth-1:0]     rsp_tdata
);

   localparam int NumStages = 5;

   // Unpack the input beat
   logic signed [alb_pkg::CompWidth-1:0]  sine_component;
   logic signed [alb_pkg::CompWidth-1:0]  cosine_component;
   logic        [alb_pkg::CountWidth-1:0] cycle_count;

   assign sine_component   = req_tdata[alb_pkg::CompWidth-1:0];
   assign cosine_component = req_tdata[2*alb_pkg::CompWidth-1:alb_pkg::CompWidth];
   assign cycle_count      = req_tdata[2*alb_pkg::CompWidth +: alb_pkg::CountWidth];

   // Stage control
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages-1:0] adv;

   always_comb begin
      adv[NumStages-1] = !vld_ff[NumStages-1] || rsp_tready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NumStages-1];

   // Stage 1: scaled magnitudes, range check on the cycle count
   logic [alb_pkg::MagWidth-1:0] mag_s_in, mag_c_in;
   logic [alb_pkg::MagWidth-1:0] mag_s_ff, mag_c_ff;
   logic                         n_ok_in;
   logic [alb_pkg::FracBits-1:0] cidx_in;
   logic                         n_ok1_ff, n_ok2_ff, n_ok3_ff;
   logic [alb_pkg::FracBits-1:0] cidx1_ff, cidx2_ff, cidx3_ff;

   alb_mag u_mag_s (
      .comp (sine_component),
      .mag  (mag_s_in)
   );

   alb_mag u_mag_c (
      .comp (cosine_component),
      .mag  (mag_c_in)
   );

   assign n_ok_in = (cycle_count != '0) &&
                    (cycle_count <= alb_pkg::CountWidth'(alb_pkg::TableLen));
   assign cidx_in = alb_pkg::FracBits'(cycle_count - 1'b1);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mag_s_ff <= mag_s_in;
         mag_c_ff <= mag_c_in;
         n_ok1_ff <= n_ok_in;
         cidx1_ff <= cidx_in;
      end
   end

   // Stage 2: halved squares added
   logic [alb_pkg::SumWidth-1:0] sum_in, sum_ff;

   alb_sqsum u_sqsum (
      .mag_s (mag_s_ff),
      .mag_c (mag_c_ff),
      .sum   (sum_in)
   );

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sum_ff   <= sum_in;
         n_ok2_ff <= n_ok1_ff;
         cidx2_ff <= cidx1_ff;
      end
   end

   // Stage 3: leading-one position and mantissa index
   alb_pkg::lod_type lod_in, lod_ff;

   alb_lod u_lod (
      .sum (sum_ff),
      .lod (lod_in)
   );

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         lod_ff   <= lod_in;
         n_ok3_ff <= n_ok2_ff;
         cidx3_ff <= cidx2_ff;
      end
   end

   // Stage 4: log, halving, cycle-count correction, floor
   logic [alb_pkg::LogWidth-1:0] log_in, log_ff;
   logic                         live_in, live_ff;

   alb_corr u_corr (
      .lod     (lod_ff),
      .n_ok    (n_ok3_ff),
      .cidx    (cidx3_ff),
      .log_val (log_in),
      .live    (live_in)
   );

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         log_ff  <= log_in;
         live_ff <= live_in;
      end
   end

   // Stage 5: exp2 back to brightness, held in the output register
   logic [alb_pkg::BrightWidth-1:0] bright_in, bright_ff;

   alb_exp2 u_exp2 (
      .log_val (log_ff),
      .live    (live_ff),
      .bright  (bright_in)
   );

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         bright_ff <= bright_in;
      end
   end

   assign rsp_tdata = bright_ff;

endmodule
